// File: sv/dsp_pkg.sv
// Shared types and command codes for the shortest-path engine.
`default_nettype none
package dsp_pkg;
  localparam logic [1:0] CMD_WRITE_SLOT  = 2'd0;
  localparam logic [1:0] CMD_SET_ENABLED = 2'd1;
  localparam logic [1:0] CMD_SEARCH      = 2'd2;
  localparam logic [1:0] CMD_RESERVED    = 2'd3;   // no action, no result

  // width of a path cost; sums saturate at all ones
  localparam int COST_BITS = 21;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_slot;      // write adjacency slot from input beat
    logic wr_en;        // write node enabled flag
    logic init;         // clear search state, seed start
    logic scan_clr;     // reset scan minimum
    logic scan_step;    // examine node at scan index
    logic take_min;     // remove chosen node from frontier
    logic edge_rd;      // issue adjacency read
    logic relax;        // relax edge from read data
    logic walk_init;    // begin walk back from goal
    logic walk_step;    // store path node, follow predecessor
    logic out_load;     // load output register with next path node
    logic out_nf;       // load output register with not-found beat
  } dsp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic endpoints_ok;
    logic scan_done;
    logic have_min;
    logic min_is_goal;
    logic edge_done;
    logic goal_reached;
    logic walk_at_start;
    logic walk_overrun;
    logic emit_done;
  } dsp_stat_t;
endpackage
`default_nettype wire

// File: sv/dsp_datapath.sv
// Datapath: graph stores, cost tables, frontier scan, relaxation and path buffer.
`default_nettype none
module dsp_datapath #(
  parameter int NUM_NODES   = 32,
  parameter int MAX_DEGREE  = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dsp_pkg::dsp_cmd_t cmd,
  output dsp_pkg::dsp_stat_t     stat,
  input  wire logic [4:0]        in_node,
  input  wire logic [2:0]        in_slot,
  input  wire logic [4:0]        in_nb,
  input  wire logic [15:0]       in_weight,
  input  wire logic              in_flag,
  input  wire logic [4:0]        in_goal,
  output logic [4:0]             o_node,
  output logic                   o_found,
  output logic                   o_last
);
  localparam int NB    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int DB    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int NS    = NUM_NODES * MAX_DEGREE;
  localparam int SB    = $clog2(NS);
  localparam int CB    = dsp_pkg::COST_BITS;
  localparam int CNTB  = NB + 1;
  localparam int DCNTB = DB + 1;

  // adjacency memory: target and weight, undefined until written
  logic [4:0]             adj_tgt_mem [NS];
  logic [WEIGHT_BITS-1:0] adj_w_mem   [NS];
  logic [NS-1:0]          adj_valid_r;
  logic [NUM_NODES-1:0]   enabled_r, reached_r, pending_r;
  logic [CB-1:0]          cost_r [NUM_NODES];
  logic [NB-1:0]          pred_r [NUM_NODES];
  logic [NB-1:0]          pbuf_mem [NUM_NODES];

  logic [NB-1:0]   start_r, goal_r, scan_r, min_r, cur_r, walk_r;
  logic            scan_end_r, have_min_r, ep_ok_r;
  logic [CB-1:0]   min_cost_r, cur_cost_r;
  logic [DCNTB-1:0] deg_r;
  logic [4:0]      rd_tgt_r;
  logic [WEIGHT_BITS-1:0] rd_w_r;
  logic            rd_v_r;
  logic [CNTB-1:0] len_r, emit_r;
  logic [NB-1:0]   pb_rd_r;

  wire in_node_ok = {2'b00, in_node} < 7'(NUM_NODES);
  wire in_slot_ok = {2'b00, in_slot} < 5'(MAX_DEGREE);
  wire [NB-1:0] in_node_i = NB'(in_node);
  wire [SB-1:0] wr_idx = SB'(in_node) * SB'(MAX_DEGREE) + SB'(in_slot);
  wire [SB-1:0] rd_idx = SB'(cur_r) * SB'(MAX_DEGREE) + SB'(deg_r[DB-1:0]);
  wire [NB-1:0] tgt = NB'(rd_tgt_r);
  wire tgt_ok = ({2'b00, rd_tgt_r} < 7'(NUM_NODES)) && enabled_r[tgt];
  wire [CB:0] sum = {1'b0, cur_cost_r} + (CB+1)'(rd_w_r);
  wire [CB-1:0] nc = sum[CB] ? {CB{1'b1}} : sum[CB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_slot && in_node_ok && in_slot_ok) begin
      adj_tgt_mem[wr_idx] <= in_nb;
      adj_w_mem[wr_idx]   <= WEIGHT_BITS'(in_weight);
    end
    if (cmd.edge_rd) begin
      rd_tgt_r <= adj_tgt_mem[rd_idx];
      rd_w_r   <= adj_w_mem[rd_idx];
      rd_v_r   <= adj_valid_r[rd_idx];
    end
    if (cmd.walk_step) pbuf_mem[len_r[NB-1:0]] <= walk_r;
    pb_rd_r <= pbuf_mem[NB'(len_r - 1'b1 - emit_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_valid_r <= '0; enabled_r <= '0; reached_r <= '0; pending_r <= '0;
      deg_r <= '0; len_r <= '0; emit_r <= '0; scan_end_r <= 1'b0;
      have_min_r <= 1'b0; ep_ok_r <= 1'b0;
    end else begin
      if (cmd.wr_slot && in_node_ok && in_slot_ok) adj_valid_r[wr_idx] <= in_flag;
      if (cmd.wr_en && in_node_ok) enabled_r[in_node_i] <= in_flag;
      if (cmd.init) begin
        ep_ok_r <= in_node_ok && ({2'b00, in_goal} < 7'(NUM_NODES));
        start_r <= in_node_i;
        goal_r  <= NB'(in_goal);
        reached_r <= '0; pending_r <= '0;
        if (in_node_ok) begin
          reached_r[in_node_i] <= 1'b1;
          pending_r[in_node_i] <= 1'b1;
          cost_r[in_node_i] <= '0;
          pred_r[in_node_i] <= in_node_i;
        end
      end
      if (cmd.scan_clr) begin
        scan_r <= '0; have_min_r <= 1'b0; scan_end_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        // strict less keeps the lowest index on ties
        if (pending_r[scan_r] && (!have_min_r || cost_r[scan_r] < min_cost_r)) begin
          have_min_r <= 1'b1; min_r <= scan_r; min_cost_r <= cost_r[scan_r];
        end
        if ({1'b0, scan_r} == CNTB'(NUM_NODES - 1)) scan_end_r <= 1'b1;
        else scan_r <= scan_r + 1'b1;
      end
      if (cmd.take_min) begin
        pending_r[min_r] <= 1'b0;
        cur_r <= min_r; cur_cost_r <= min_cost_r; deg_r <= '0;
      end
      if (cmd.edge_rd) deg_r <= deg_r + 1'b1;
      if (cmd.relax && rd_v_r && tgt_ok && (!reached_r[tgt] || nc < cost_r[tgt])) begin
        reached_r[tgt] <= 1'b1; pending_r[tgt] <= 1'b1;
        cost_r[tgt] <= nc; pred_r[tgt] <= cur_r;
      end
      if (cmd.walk_init) begin
        walk_r <= goal_r; len_r <= '0; emit_r <= '0;
      end
      if (cmd.walk_step) begin
        len_r <= len_r + 1'b1;
        walk_r <= pred_r[walk_r];
      end
      if (cmd.out_load) emit_r <= emit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_node <= 5'(pb_rd_r); o_found <= 1'b1; o_last <= (emit_r + 1'b1 == len_r);
    end else if (cmd.out_nf) begin
      o_node <= '0; o_found <= 1'b0; o_last <= 1'b1;
    end
  end

  always_comb begin
    stat.endpoints_ok  = ep_ok_r;
    stat.scan_done     = scan_end_r;
    stat.have_min      = have_min_r;
    stat.min_is_goal   = (min_r == goal_r);
    stat.edge_done     = (deg_r == DCNTB'(MAX_DEGREE));
    stat.goal_reached  = reached_r[goal_r];
    stat.walk_at_start = (walk_r == start_r);
    stat.walk_overrun  = (len_r == CNTB'(NUM_NODES));
    stat.emit_done     = (emit_r == len_r);
  end
endmodule
`default_nettype wire

// File: sv/dsp_ctrl.sv
// Controller state machine sequencing loads, search, walk back and output beats.
`default_nettype none
module dsp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [1:0]         in_cmd,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dsp_pkg::dsp_cmd_t       cmd,
  input  wire dsp_pkg::dsp_stat_t stat
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_PICK  = 11'b00000001000,
    S_EREAD = 11'b00000010000,
    S_RELAX = 11'b00000100000,
    S_WALK  = 11'b00001000000,
    S_PRE   = 11'b00010000000,
    S_LOAD  = 11'b00100000000,
    S_SEND  = 11'b01000000000,
    S_NF    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.wr_slot = (in_cmd == dsp_pkg::CMD_WRITE_SLOT);
          cmd.wr_en   = (in_cmd == dsp_pkg::CMD_SET_ENABLED);
          if (in_cmd == dsp_pkg::CMD_SEARCH) begin
            cmd.init = 1'b1; state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.scan_clr = 1'b1;
        state_nxt = stat.endpoints_ok ? S_SCAN : S_NF;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_PICK;
        else cmd.scan_step = 1'b1;
      end
      S_PICK: begin
        if (!stat.have_min) state_nxt = stat.goal_reached ? S_WALK : S_NF;
        else begin
          cmd.take_min = 1'b1;
          state_nxt = stat.min_is_goal ? S_WALK : S_EREAD;
        end
        cmd.walk_init = !stat.have_min || stat.min_is_goal;
      end
      S_EREAD: begin
        if (stat.edge_done) begin
          cmd.scan_clr = 1'b1; state_nxt = S_SCAN;
        end else begin
          cmd.edge_rd = 1'b1; state_nxt = S_RELAX;
        end
      end
      S_RELAX: begin
        cmd.relax = 1'b1; state_nxt = S_EREAD;
      end
      S_WALK: begin
        if (stat.walk_overrun) state_nxt = S_NF;
        else begin
          cmd.walk_step = 1'b1;
          if (stat.walk_at_start) state_nxt = S_PRE;
        end
      end
      S_PRE: state_nxt = S_LOAD;   // path buffer read settles
      S_LOAD: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; state_nxt = S_SEND;
        end
      end
      S_SEND: state_nxt = stat.emit_done ? S_IDLE : S_LOAD;
      S_NF: begin
        if (!ov_r || out_ready) begin
          cmd.out_nf = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// File: sv/dijkstra_shortest_path.sv
// Top level of the Dijkstra shortest-path engine.
// Graph writes (cmd 0 slot, cmd 1 enable) are done as the beat is taken in the
// idle state. A search scans the frontier one node per cycle for each selected
// node, then reads each adjacency slot through a registered read and relaxes
// the edge, then walks back from the goal with a settle state for the buffer
// read, and sends the result beats through a load and a send state each, start first.
// Input is taken only when idle with no result beat pending.
`default_nettype none
module dijkstra_shortest_path #(
  parameter int NUM_NODES   = 32,
  parameter int MAX_DEGREE  = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: cmd[1:0], node[6:2], slot[9:7], neighbour[14:10], weight[30:15],
  //        flag[31], goal[36:32], zero fill [39:37]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: path_node[4:0], found[5], zero fill [7:6]
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);
  dsp_pkg::dsp_cmd_t  cmd;
  dsp_pkg::dsp_stat_t stat;
  logic [4:0] o_node;
  logic       o_found;

  wire in_fire = in_tvalid && in_tready;

  dsp_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_cmd(in_tdata[1:0]), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd, .stat
  );

  dsp_datapath #(
    .NUM_NODES(NUM_NODES), .MAX_DEGREE(MAX_DEGREE), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_node(in_tdata[6:2]), .in_slot(in_tdata[9:7]), .in_nb(in_tdata[14:10]),
    .in_weight(in_tdata[30:15]), .in_flag(in_tdata[31]), .in_goal(in_tdata[36:32]),
    .o_node, .o_found, .o_last(out_tlast)
  );

  assign out_tdata = {2'b00, o_found, o_node};
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the Dijkstra shortest-path engine.
`default_nettype none
module tb_top;
  localparam int NODES  = 32;
  localparam int DEGREE = 8;
  localparam int LIMIT  = 4000000;
  localparam logic [20:0] COST_SAT = 21'h1FFFFF;

  // one input beat as the block sees it
  typedef struct packed {
    logic [4:0]  goal;
    logic        flag;
    logic [15:0] weight;
    logic [4:0]  neighbour;
    logic [2:0]  slot;
    logic [4:0]  node;
    logic [1:0]  cmd;
  } cmd_beat_t;

  // one expected path beat: {found, path_node} plus last
  typedef struct packed {
    logic       last;
    logic       found;
    logic [4:0] path_node;
  } hop_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  dijkstra_shortest_path DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the graph
  logic [4:0]  g_target [NODES*DEGREE];
  logic [15:0] g_weight [NODES*DEGREE];
  logic        g_valid  [NODES*DEGREE];
  logic        g_enabled[NODES];
  logic [20:0] g_cost   [NODES];
  logic [4:0]  g_pred   [NODES];

  hop_t path_queue[$];
  int   errors = 0;
  int   cycles = 0;
  int   out_gap = 0;  // remaining sink stall cycles
  bit   calm   = 1'b0;   // no idling in the closing stretch

  // directed table: searches on an empty graph, graph extremes, special cases, then searches
  cmd_beat_t plan[$];
  hop_t      fixed[$];   // expected result where obvious; SKIP for shadow-only rows
  localparam hop_t SKIP = '{1'b0, 1'b1, 5'd31};

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  function automatic void queue_hop(input logic is_last, input logic is_found,
                                    input logic [4:0] node_id);
    hop_t h;
    h.last = is_last;
    h.found = is_found;
    h.path_node = node_id;
    path_queue.insert(path_queue.size(), h);
  endfunction

  function automatic void add_row(input cmd_beat_t b, input hop_t h);
    plan.insert(plan.size(), b);
    fixed.insert(fixed.size(), h);
  endfunction

  // update the shadow graph and queue the path a search should give
  task automatic predict_path(input cmd_beat_t b);
    logic reached[NODES];
    logic pend[NODES];
    logic [4:0] trail[$];
    logic [21:0] sum;
    int cur, idx, t, walk;
    bit ok;
    case (b.cmd)
      dsp_pkg::CMD_WRITE_SLOT: begin
        idx = b.node * DEGREE + b.slot;
        g_target[idx] = b.neighbour;
        g_weight[idx] = b.weight;
        g_valid[idx]  = b.flag;
      end
      dsp_pkg::CMD_SET_ENABLED: g_enabled[b.node] = b.flag;
      dsp_pkg::CMD_SEARCH: begin
        foreach (reached[i]) begin
          reached[i] = 1'b0;
          pend[i] = 1'b0;
        end
        reached[b.node] = 1'b1;
        pend[b.node] = 1'b1;
        g_cost[b.node] = '0;
        g_pred[b.node] = b.node;
        forever begin
          cur = -1;
          for (int n = 0; n < NODES; n++)
            if (pend[n] && (cur < 0 || g_cost[n] < g_cost[cur])) cur = n;
          if (cur < 0) break;
          pend[cur] = 1'b0;
          if (cur == b.goal) break;
          for (int d = 0; d < DEGREE; d++) begin
            idx = cur * DEGREE + d;
            if (!g_valid[idx]) continue;
            t = g_target[idx];
            if (!g_enabled[t]) continue;
            sum = g_cost[cur] + g_weight[idx];
            if (sum > COST_SAT) sum = COST_SAT;
            if (!reached[t] || sum[20:0] < g_cost[t]) begin
              reached[t] = 1'b1;
              pend[t] = 1'b1;
              g_cost[t] = sum[20:0];
              g_pred[t] = cur[4:0];
            end
          end
        end
        ok = 1'b0;
        if (reached[b.goal]) begin
          walk = b.goal;
          while (trail.size() < NODES) begin
            trail.insert(0, walk[4:0]);
            if (walk == b.node) begin
              ok = 1'b1;
              break;
            end
            walk = g_pred[walk];
          end
        end
        if (!ok) queue_hop(1'b1, 1'b0, 5'd0);
        else foreach (trail[k])
          queue_hop(k == trail.size() - 1, 1'b1, trail[k]);
      end
      default: ;
    endcase
  endtask

  function automatic cmd_beat_t mk(input logic [1:0] c, input int n, input int s,
                                   input int nb, input int w, input bit f, input int g);
    cmd_beat_t b;
    b = '{goal: 5'(g), flag: f, weight: 16'(w), neighbour: 5'(nb), slot: 3'(s),
          node: 5'(n), cmd: c};
    return b;
  endfunction

  // hand one beat to the block, with optional idle burst before it
  task automatic send(input cmd_beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata  <= {3'b000, b};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_path(b);
  endtask

  // drop valid and hold until every expected result has come
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (path_queue.size() != 0) @(posedge clk);
  endtask

  // sink side: random stall bursts, check every beat against the oldest entry
  always @(posedge clk) begin
    hop_t want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (path_queue.size() == 0) report($sformatf("unexpected beat %h", out_tdata));
      else begin
        want = path_queue.pop_front();
        if (out_tdata[4:0] !== want.path_node)
          report($sformatf("path_node %0d, want %0d", out_tdata[4:0], want.path_node));
        if (out_tdata[5] !== want.found)
          report($sformatf("found %b, want %b", out_tdata[5], want.found));
        if (out_tlast !== want.last)
          report($sformatf("last %b, want %b", out_tlast, want.last));
        if (out_tdata[7:6] !== 2'b00) report("zero fill not zero");
      end
    end
    if (calm) out_tready <= 1'b1;
    else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_gap <= int'($urandom_range(0, 3));
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  always @(posedge clk)
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end

  initial begin
    cmd_beat_t b;
    int n, busy;
    foreach (g_valid[i]) begin
      g_target[i] = '0;
      g_weight[i] = '0;
      g_valid[i]  = 1'b0;
    end
    foreach (g_enabled[i]) begin
      g_enabled[i] = 1'b0;
      g_cost[i]    = '0;
      g_pred[i]    = '0;
    end

    // search on an empty graph: start equals goal, then unreachable goal
    add_row(mk(dsp_pkg::CMD_SEARCH, 7, 0, 0, 0, 0, 7), '{1'b1, 1'b1, 5'd7});
    add_row(mk(dsp_pkg::CMD_SEARCH, 0, 0, 0, 0, 0, 31), '{1'b1, 1'b0, 5'd0});
    add_row(mk(dsp_pkg::CMD_RESERVED, 31, 7, 31, 65535, 1, 31), SKIP);
    add_row(mk(dsp_pkg::CMD_SET_ENABLED, 31, 0, 0, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_SET_ENABLED, 1, 0, 0, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_SET_ENABLED, 2, 0, 0, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_WRITE_SLOT, 0, 0, 31, 65535, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_WRITE_SLOT, 0, 7, 1, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_WRITE_SLOT, 1, 3, 31, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_WRITE_SLOT, 0, 1, 2, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_WRITE_SLOT, 2, 0, 31, 0, 1, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_SEARCH, 0, 0, 0, 0, 0, 31), SKIP);  // tie 1 vs 2
    add_row(mk(dsp_pkg::CMD_WRITE_SLOT, 0, 7, 1, 0, 0, 0), SKIP);  // drop slot
    add_row(mk(dsp_pkg::CMD_SET_ENABLED, 2, 0, 0, 0, 0, 0), SKIP);
    add_row(mk(dsp_pkg::CMD_SEARCH, 0, 0, 0, 0, 0, 31), SKIP);
    add_row(mk(dsp_pkg::CMD_SEARCH, 0, 0, 0, 0, 0, 2), '{1'b1, 1'b0, 5'd0});
    add_row(mk(dsp_pkg::CMD_SEARCH, 31, 0, 0, 0, 0, 0), '{1'b1, 1'b0, 5'd0});
    add_row(mk(dsp_pkg::CMD_SEARCH, 0, 0, 0, 0, 0, 0), '{1'b1, 1'b1, 5'd0});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (fixed[i] != SKIP) begin
        drain();
        send(plan[i]);
        if (path_queue.size() != 1 || path_queue[0] != fixed[i])
          report($sformatf("row %0d: shadow disagrees with table", i));
      end else send(plan[i]);
    end

    // build a dense chain so long paths appear, every node enabled
    for (n = 0; n < NODES; n++) send(mk(dsp_pkg::CMD_SET_ENABLED, n, 0, 0, 0, 1, 0));
    for (n = 0; n < NODES - 1; n++)
      send(mk(dsp_pkg::CMD_WRITE_SLOT, n, 0, n + 1, 1, 1, 0));
    send(mk(dsp_pkg::CMD_SEARCH, 0, 0, 0, 0, 0, 31));   // search from node 0 to node 31

    // pause until the block has given every result
    drain();
    repeat (2000) @(posedge clk);

    // random mix: mostly slot writes into a well-connected graph, plus enables, reserved codes and searches
    for (int k = 0; k < 240; k++) begin
      if (k == 200) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          b = mk(dsp_pkg::CMD_WRITE_SLOT, $urandom_range(0, 31), $urandom_range(0, 7),
                 $urandom_range(0, 31),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 40),
                 $urandom_range(0, 4) != 0, $urandom_range(0, 31));
        5:
          b = mk(dsp_pkg::CMD_SET_ENABLED, $urandom_range(0, 31), $urandom_range(0, 7),
                 $urandom_range(0, 31), $urandom_range(0, 65535),
                 $urandom_range(0, 5) != 0, $urandom_range(0, 31));
        6:
          b = mk(dsp_pkg::CMD_RESERVED, $urandom_range(0, 31), $urandom_range(0, 7),
                 $urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 1),
                 $urandom_range(0, 31));
        default:
          b = mk(dsp_pkg::CMD_SEARCH, $urandom_range(0, 31), $urandom_range(0, 7),
                 $urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 1),
                 $urandom_range(0, 31));
      endcase
      send(b);
    end

    drain();
    busy = 0;
    while (busy < 3000) begin
      @(posedge clk);
      busy++;
    end
    if (errors == 0 && path_queue.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
